/* rtl/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg: shared constants for the polygon point containment block
// Default sizes of the vertex store and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int NUM_FENCES_DEF   = 8;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 32;

  localparam int FenceW   = 3;
  localparam int VertexW  = 4;
  localparam int InCoordW = 32;

  localparam int MinVertices = 3;

endpackage

/* rtl/polygon_point_containment_top.sv */
// A vertex write is accepted while idle and does not raise busy_o. A test walks the
// stored vertices of the fence with the single shared multiplier, used twice per straddling edge.
// A test of a fence that does not exist returns its result in the next cycle.
// After reset the vertex memory is cleared, one entry a cycle, while busy_o is high;
// results cannot be stalled.
// ----------------------------------------------------------------------------
// polygon_point_containment_top: even-odd point in polygon test
// Stores fence vertices in a memory and walks the edges of one fence with a
// small sequencer around one multiplier and one wide compare.
// ----------------------------------------------------------------------------
module polygon_point_containment_top #(
  parameter int NUM_FENCES   = ppc_pkg::NUM_FENCES_DEF,
  parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               mode_i,
  input  logic [ppc_pkg::FenceW-1:0]         fence_index_i,
  input  logic [ppc_pkg::VertexW-1:0]        vertex_index_i,
  input  logic signed [ppc_pkg::InCoordW-1:0] lat_value_i,
  input  logic signed [ppc_pkg::InCoordW-1:0] lng_value_i,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic                               enough_vertices_o,
  output logic [ppc_pkg::FenceW-1:0]         tested_fence_o
);

  import ppc_pkg::*;

  localparam int Depth = NUM_FENCES * MAX_VERTICES;
  localparam int AW    = $clog2(Depth);
  localparam int KW    = $clog2(MAX_VERTICES);
  localparam int CW    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [AW-1:0]        clr_addr_q;
  logic [AW-1:0]        base_q;
  logic [KW-1:0]        k_q;
  logic                 closing_q;
  logic                 inside_q;
  logic                 done_q;
  logic                 res_inside_q;
  logic                 res_enough_q;
  logic [FenceW-1:0]    res_fence_q;
  logic [FenceW-1:0]    fence_q;

  logic signed [CW-1:0] px_q, py_q;
  logic signed [CW-1:0] v0_lat_q, v0_lng_q;
  logic signed [CW-1:0] cur_lat_q, cur_lng_q;
  logic signed [CW-1:0] prev_lat_q, prev_lng_q;
  logic signed [CW-1:0] rd_lat_q, rd_lng_q;
  logic                 dneg_q;
  logic signed [PW-1:0] prod_q, left_q;

  logic signed [CW-1:0] lat_mem [Depth];
  logic signed [CW-1:0] lng_mem [Depth];

  logic                 accept;
  logic                 fence_ok;
  logic                 vtx_ok;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic signed [CW-1:0] mem_wlat, mem_wlng;
  logic signed [CW-1:0] in_lat, in_lng;
  logic                 lat_zero;
  logic                 straddle;
  logic signed [DW-1:0] dy_edge;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 crossing;
  logic                 last_slot;
  logic                 enough_cnt;

  assign accept   = start_i && !busy_o;
  assign fence_ok = int'(fence_index_i) < NUM_FENCES;
  assign vtx_ok   = int'(vertex_index_i) < MAX_VERTICES;
  assign in_lat   = CW'(lat_value_i);
  assign in_lng   = CW'(lng_value_i);

  assign mem_we   = (state_q == S_CLEAR) || (accept && !mode_i && fence_ok && vtx_ok);
  assign mem_wa   = (state_q == S_CLEAR) ? clr_addr_q :
                    AW'(int'(fence_index_i) * MAX_VERTICES + int'(vertex_index_i));
  assign mem_wlat = (state_q == S_CLEAR) ? '0 : in_lat;
  assign mem_wlng = (state_q == S_CLEAR) ? '0 : in_lng;
  assign mem_ra   = base_q + AW'(k_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lat_mem[mem_wa] <= mem_wlat;
      lng_mem[mem_wa] <= mem_wlng;
    end
    rd_lat_q <= lat_mem[mem_ra];
    rd_lng_q <= lng_mem[mem_ra];
  end

  assign lat_zero   = (rd_lat_q == '0);
  assign straddle   = (cur_lng_q < py_q) != (prev_lng_q < py_q);
  assign dy_edge    = DW'(prev_lng_q) - DW'(cur_lng_q);
  assign last_slot  = (int'(k_q) + 1) == MAX_VERTICES;
  assign enough_cnt = int'(k_q) >= MinVertices;

  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = DW'(py_q) - DW'(cur_lng_q);
      mul_b = DW'(prev_lat_q) - DW'(cur_lat_q);
    end else begin
      mul_a = DW'(px_q) - DW'(cur_lat_q);
      mul_b = dy_edge;
    end
  end

  assign mul_p    = PW'(mul_a) * PW'(mul_b);
  assign crossing = dneg_q ? (prod_q < left_q) : (left_q < prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && mode_i && fence_ok) state_d = S_READ;
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (lat_zero) begin
          state_d = enough_cnt ? S_TEST : S_IDLE;
        end else begin
          state_d = (k_q == '0) ? S_NEXT : S_TEST;
        end
      end
      S_TEST:  state_d = straddle ? S_MUL1 : S_NEXT;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_CMP;
      S_CMP:   state_d = S_NEXT;
      S_NEXT: begin
        if (closing_q) state_d = S_IDLE;
        else if (last_slot) state_d = S_TEST;
        else state_d = S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      base_q       <= '0;
      k_q          <= '0;
      closing_q    <= 1'b0;
      inside_q     <= 1'b0;
      done_q       <= 1'b0;
      res_inside_q <= 1'b0;
      res_enough_q <= 1'b0;
      res_fence_q  <= '0;
      fence_q      <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
        S_IDLE: begin
          if (accept && mode_i) begin
            fence_q   <= fence_index_i;
            base_q    <= AW'(int'(fence_index_i) * MAX_VERTICES);
            k_q       <= '0;
            closing_q <= 1'b0;
            inside_q  <= 1'b0;
            if (!fence_ok) begin
              done_q       <= 1'b1;
              res_inside_q <= 1'b0;
              res_enough_q <= 1'b0;
              res_fence_q  <= fence_index_i;
            end
          end
        end
        S_CHECK: begin
          if (lat_zero) begin
            closing_q <= 1'b1;
            if (!enough_cnt) begin
              done_q       <= 1'b1;
              res_inside_q <= 1'b0;
              res_enough_q <= 1'b0;
              res_fence_q  <= fence_q;
            end
          end
        end
        S_CMP: begin
          if (crossing) inside_q <= !inside_q;
        end
        S_NEXT: begin
          if (closing_q) begin
            done_q       <= 1'b1;
            res_inside_q <= inside_q;
            res_enough_q <= 1'b1;
            res_fence_q  <= fence_q;
          end else if (last_slot) begin
            closing_q <= 1'b1;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mode_i) begin
      px_q <= in_lat;
      py_q <= in_lng;
    end
    case (state_q)
      S_CHECK: begin
        if (lat_zero) begin
          cur_lat_q <= v0_lat_q;
          cur_lng_q <= v0_lng_q;
        end else begin
          cur_lat_q <= rd_lat_q;
          cur_lng_q <= rd_lng_q;
          if (k_q == '0) begin
            v0_lat_q <= rd_lat_q;
            v0_lng_q <= rd_lng_q;
          end
        end
      end
      S_TEST: begin
        dneg_q <= dy_edge[DW-1];
      end
      S_MUL1: begin
        prod_q <= mul_p;
      end
      S_MUL2: begin
        left_q <= prod_q;
        prod_q <= mul_p;
      end
      S_NEXT: begin
        if (!closing_q) begin
          prev_lat_q <= cur_lat_q;
          prev_lng_q <= cur_lng_q;
          if (last_slot) begin
            cur_lat_q <= v0_lat_q;
            cur_lng_q <= v0_lng_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign inside_res_o      = res_inside_q;
  assign enough_vertices_o = res_enough_q;
  assign tested_fence_o    = res_fence_q;

  a_inside_needs_vertices : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_res_o |-> enough_vertices_o)
    else $error("Inside reported for a fence without enough vertices.");

  a_enough_after_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && enough_vertices_o |-> $past(state_q == S_NEXT) && $past(closing_q))
    else $error("Full result given without finishing the closing edge.");

  a_slot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(k_q) < MAX_VERTICES)
    else $error("Vertex slot counter ran past the fence size.");

  a_test_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_i && fence_ok |=> busy_o && !done_o)
    else $error("Accepted test of a valid fence did not start the edge walk.");

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> busy_o && !done_o)
    else $error("Block became ready during the memory clearing pass.");

endmodule

/* tb/polygon_point_containment_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_point_containment_checker: result checker for the containment block
// Watches the command and result channels, keeps its own vertex store, and
// predicts every test with an exact even-odd ray casting walk. Each result is
// compared with the oldest pending prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module polygon_point_containment_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic                                mode_i,
  input  logic [ppc_pkg::FenceW-1:0]          fence_index_i,
  input  logic [ppc_pkg::VertexW-1:0]         vertex_index_i,
  input  logic signed [ppc_pkg::InCoordW-1:0] lat_value_i,
  input  logic signed [ppc_pkg::InCoordW-1:0] lng_value_i,
  input  logic                                done_i,
  input  logic                                inside_res_i,
  input  logic                                enough_vertices_i,
  input  logic [ppc_pkg::FenceW-1:0]          tested_fence_i,
  output int                                  error_count_o,
  output int                                  outstanding_o
);

  localparam int NumFences   = ppc_pkg::NUM_FENCES_DEF;
  localparam int MaxVertices = ppc_pkg::MAX_VERTICES_DEF;
  localparam int StoreDepth  = NumFences * MaxVertices;
  localparam logic ModeWrite = 1'b0;

  typedef struct packed {
    logic                       in_poly;
    logic                       enough;
    logic [ppc_pkg::FenceW-1:0] fence;
  } verdict_t;

  logic signed [ppc_pkg::InCoordW-1:0] fence_lat[StoreDepth];
  logic signed [ppc_pkg::InCoordW-1:0] fence_lng[StoreDepth];
  verdict_t pending_verdicts[$];
  int       mismatches = 0;

  initial begin
    for (int k = 0; k < StoreDepth; k++) begin
      fence_lat[k] = '0;
      fence_lng[k] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic verdict_t predict_containment(input int unsigned fence,
                                                   input longint px, input longint py);
    verdict_t           v;
    int unsigned        base;
    int unsigned        count;
    int unsigned        j;
    longint             xi, yi, xj, yj;
    logic signed [127:0] fa, fb, lhs, rhs;
    bit                 yi_lo, yj_lo, crossing;
    v.in_poly = 1'b0;
    v.enough  = 1'b0;
    v.fence   = fence[ppc_pkg::FenceW-1:0];
    base      = fence * MaxVertices;
    count     = 0;
    while (count < MaxVertices && fence_lat[base+count] != 0) count++;
    if (count >= ppc_pkg::MinVertices) begin
      v.enough = 1'b1;
      j = count - 1;
      for (int unsigned i = 0; i < count; i++) begin
        xi    = fence_lat[base+i];
        yi    = fence_lng[base+i];
        xj    = fence_lat[base+j];
        yj    = fence_lng[base+j];
        yi_lo = yi < py;
        yj_lo = yj < py;
        if (yi_lo != yj_lo) begin
          fa       = py - yi;
          fb       = xj - xi;
          lhs      = fa * fb;
          fa       = px - xi;
          fb       = yj - yi;
          rhs      = fa * fb;
          crossing = (yj < yi) ? (rhs < lhs) : (lhs < rhs);
          if (crossing) v.in_poly = ~v.in_poly;
        end
        j = i;
      end
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result for fence %0d with no test pending",
                                    tested_fence_i));
        end else begin
          want = pending_verdicts.pop_front();
          if (inside_res_i !== want.in_poly)
            report_mismatch($sformatf("fence %0d inside_res expected %0b, got %0b",
                                      want.fence, want.in_poly, inside_res_i));
          if (enough_vertices_i !== want.enough)
            report_mismatch($sformatf("fence %0d enough_vertices expected %0b, got %0b",
                                      want.fence, want.enough, enough_vertices_i));
          if (tested_fence_i !== want.fence)
            report_mismatch($sformatf("tested_fence expected %0d, got %0d",
                                      want.fence, tested_fence_i));
        end
      end
      if (start_i && !busy_i) begin
        if (mode_i == ModeWrite) begin
          fence_lat[int'(fence_index_i) * MaxVertices + int'(vertex_index_i)] = lat_value_i;
          fence_lng[int'(fence_index_i) * MaxVertices + int'(vertex_index_i)] = lng_value_i;
        end else begin
          pending_verdicts.push_back(predict_containment(fence_index_i, lat_value_i,
                                                         lng_value_i));
        end
      end
    end
    error_count_o <= mismatches;
    outstanding_o <= pending_verdicts.size();
  end

endmodule

/* tb/tb_polygon_point_containment_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_point_containment_top: testbench for the containment block
// Drives directed fences and points, then random fence builds followed by
// point tests and some noise, with random gaps between commands. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_polygon_point_containment_top;

  localparam int   ItemTarget  = 1120;
  localparam int   CycleLimit  = 1000000;
  localparam int   DrainCycles = 150;
  localparam int   DrainAt     = 800;
  localparam int   QuietFrom   = 400;
  localparam int   QuietTo     = 600;
  localparam logic ModeWrite   = 1'b0;
  localparam logic ModeTest    = 1'b1;
  localparam int   Deg         = 1 << 22;
  localparam int   CoordMin    = 32'sh8000_0000;
  localparam int   CoordMax    = 32'sh7fff_ffff;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  logic                                mode_i;
  logic [ppc_pkg::FenceW-1:0]          fence_index_i;
  logic [ppc_pkg::VertexW-1:0]         vertex_index_i;
  logic signed [ppc_pkg::InCoordW-1:0] lat_value_i;
  logic signed [ppc_pkg::InCoordW-1:0] lng_value_i;
  logic                                done_o;
  logic                                inside_res_o;
  logic                                enough_vertices_o;
  logic [ppc_pkg::FenceW-1:0]          tested_fence_o;

  int error_count;
  int outstanding;
  int sent_items = 0;
  int cycle_count = 0;

  polygon_point_containment_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .fence_index_i    (fence_index_i),
    .vertex_index_i   (vertex_index_i),
    .lat_value_i      (lat_value_i),
    .lng_value_i      (lng_value_i),
    .done_o           (done_o),
    .inside_res_o     (inside_res_o),
    .enough_vertices_o(enough_vertices_o),
    .tested_fence_o   (tested_fence_o)
  );

  polygon_point_containment_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .mode_i           (mode_i),
    .fence_index_i    (fence_index_i),
    .vertex_index_i   (vertex_index_i),
    .lat_value_i      (lat_value_i),
    .lng_value_i      (lng_value_i),
    .done_i           (done_o),
    .inside_res_i     (inside_res_o),
    .enough_vertices_i(enough_vertices_o),
    .tested_fence_i   (tested_fence_o),
    .error_count_o    (error_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue_request(input logic m, input logic [ppc_pkg::FenceW-1:0] f,
                               input logic [ppc_pkg::VertexW-1:0] v,
                               input int lat, input int lng);
    if (!(sent_items >= QuietFrom && sent_items < QuietTo) &&
        $urandom_range(0, 99) < 14) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    mode_i         <= m;
    fence_index_i  <= f;
    vertex_index_i <= v;
    lat_value_i    <= lat;
    lng_value_i    <= lng;
    start_i        <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic write_vertex(input logic [ppc_pkg::FenceW-1:0] f,
                              input logic [ppc_pkg::VertexW-1:0] v,
                              input int lat, input int lng);
    issue_request(ModeWrite, f, v, lat, lng);
  endtask

  task automatic test_point(input logic [ppc_pkg::FenceW-1:0] f, input int lat, input int lng);
    issue_request(ModeTest, f, 4'($urandom_range(0, 15)), lat, lng);
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic int spread(input int unsigned shift);
    return $signed($urandom) >>> (31 - shift);
  endfunction

  task automatic fence_burst();
    logic [ppc_pkg::FenceW-1:0] f;
    int unsigned n, shift, k, pick;
    int clat, clng, lat, lng;
    int vlat[16];
    int vlng[16];
    f     = 3'($urandom_range(0, 7));
    n     = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 16) : $urandom_range(3, 6);
    shift = $urandom_range(2, 30);
    clat  = $urandom;
    clng  = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      lat  = clat + spread(shift);
      lng  = clng + spread(shift);
      if (lat == 0) lat = 1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        lat = 0;
      end else if (pick < 10) begin
        lat = $urandom;
        lng = $urandom;
      end
      vlat[i] = lat;
      vlng[i] = lng;
      write_vertex(f, i[3:0], lat, lng);
    end
    if (n < 16 && $urandom_range(0, 1) == 1) write_vertex(f, n[3:0], 0, $urandom);
    k = $urandom_range(1, 6);
    for (int unsigned i = 0; i < k; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        lat = vlat[$urandom_range(0, n - 1)];
        lng = vlng[$urandom_range(0, n - 1)];
      end else if (pick < 30) begin
        lat = $urandom;
        lng = $urandom;
      end else begin
        lat = clat + spread(shift);
        lng = clng + spread(shift);
      end
      test_point(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : f, lat, lng);
    end
  endtask

  initial begin
    bit drained;
    drained        = 1'b0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    mode_i         <= ModeWrite;
    fence_index_i  <= '0;
    vertex_index_i <= '0;
    lat_value_i    <= '0;
    lng_value_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_point(3'd0, 5 * Deg, 5 * Deg);

    write_vertex(3'd1, 4'd0, 10 * Deg, 10 * Deg);
    write_vertex(3'd1, 4'd1, 20 * Deg, 10 * Deg);
    write_vertex(3'd1, 4'd2, 15 * Deg, 20 * Deg);
    test_point(3'd1, 15 * Deg, 12 * Deg);
    test_point(3'd1, 30 * Deg, 12 * Deg);
    test_point(3'd1, 15 * Deg, 10 * Deg);
    test_point(3'd1, 15 * Deg, 20 * Deg);

    write_vertex(3'd2, 4'd0, 1 * Deg, 1 * Deg);
    write_vertex(3'd2, 4'd1, 2 * Deg, 1 * Deg);
    write_vertex(3'd2, 4'd2, 0, 3 * Deg);
    write_vertex(3'd2, 4'd3, 2 * Deg, 3 * Deg);
    test_point(3'd2, 2 * Deg, 2 * Deg);

    write_vertex(3'd7, 4'd0, CoordMin, CoordMin);
    write_vertex(3'd7, 4'd1, CoordMax, CoordMin);
    write_vertex(3'd7, 4'd2, CoordMax, CoordMax);
    write_vertex(3'd7, 4'd3, CoordMin, CoordMax);
    write_vertex(3'd7, 4'd15, CoordMax, CoordMin);
    test_point(3'd7, 0, 0);
    test_point(3'd7, CoordMax, CoordMin);

    while (sent_items < ItemTarget) begin
      if (!drained && sent_items >= DrainAt) begin
        wait_for_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        issue_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      4'($urandom_range(0, 15)), $urandom, $urandom);
      end else begin
        fence_burst();
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
